// File: sv/olai_pkg.sv
// Shared types and constants for the ordered list core.
// No dependencies; imported by olai_cell and the top level.
package olai_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int POS_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Control part of the operation token that walks down the cell chain.
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic             found;
        logic [POS_W-1:0] pos;
    } tok_t;

endpackage

// File: sv/olai_cell.sv
// One list slot: holds an entry and acts on the operation token passing by.
// Depends on olai_pkg.
module olai_cell #(
    parameter int DATA_WIDTH = olai_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_W    = 7,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  olai_pkg::tok_t        tok_in,
    input  logic [DATA_WIDTH-1:0] key_in,
    input  logic [COUNT_W-1:0]    cnt_in,
    input  logic [DATA_WIDTH-1:0] rdata_in,
    input  logic [DATA_WIDTH-1:0] next_entry,
    output logic [DATA_WIDTH-1:0] entry,
    output olai_pkg::tok_t        tok_out,
    output logic [DATA_WIDTH-1:0] key_out,
    output logic [COUNT_W-1:0]    cnt_out,
    output logic [DATA_WIDTH-1:0] rdata_out
);
    import olai_pkg::*;

    localparam int CMP_W = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(INDEX);
    localparam logic [CMP_W-1:0]   MY_CMP = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg, entry_next;
    tok_t                  tok_reg, tok_next;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;

    logic in_list, hit_here, match_here;

    assign in_list = MY_IDX < cnt_in;

    always_comb begin
        entry_next = entry_reg;
        hit_here   = 1'b0;
        match_here = 1'b0;
        if (tok_in.valid) begin
            case (tok_in.op)
                OP_APPEND: begin
                    if (MY_IDX == cnt_in) entry_next = key_in;
                end
                OP_READ: begin
                    hit_here = in_list && (MY_CMP == CMP_W'(tok_in.pos));
                end
                OP_REMOVE: begin
                    match_here = in_list && !tok_in.found && (entry_reg == key_in);
                    // close the gap: every slot from the match on takes its neighbor
                    if (in_list && (tok_in.found || match_here)) entry_next = next_entry;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found || match_here || hit_here;
        rdata_next     = hit_here ? entry_reg : rdata_in;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        key_reg   <= key_in;
        cnt_reg   <= cnt_in;
        rdata_reg <= rdata_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign entry     = entry_reg;
    assign tok_out   = tok_reg;
    assign key_out   = key_reg;
    assign cnt_out   = cnt_reg;
    assign rdata_out = rdata_reg;

endmodule

// File: sv/ordered_list_append_index_remove_core.sv
// Ordered list core: append, read at index, remove first match, on a chain of cells.
// The token passes through the CAPACITY cell registers; its result is then registered onto m_valid.
// One operation is in flight at a time; the token walks one cell per cycle.
// Reset (aresetn low, synchronous): count cleared, chain and output emptied.
// Entry contents are not cleared; slots at or past the count are never read.
// Depends on olai_pkg and olai_cell.
module ordered_list_append_index_remove_core #(
    parameter int CAPACITY   = olai_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = olai_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic        [olai_pkg::OP_W-1:0]        s_opcode,
    input  logic signed [olai_pkg::VALUE_W-1:0]     s_value,
    input  logic        [olai_pkg::POS_W-1:0]       s_position,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic        [olai_pkg::ST_W-1:0]        m_status,
    output logic signed [olai_pkg::VALUE_W-1:0]     m_read_data,
    output logic        [olai_pkg::COUNT_OUT_W-1:0] m_entry_count
);
    import olai_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Chain links: link i feeds cell i, link CAPACITY is the chain's exit.
    tok_t                  tok_chain   [0:CAPACITY];
    logic [DATA_WIDTH-1:0] key_chain   [0:CAPACITY];
    logic [CW-1:0]         cnt_chain   [0:CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_chain [0:CAPACITY];
    logic [DATA_WIDTH-1:0] entry_q     [0:CAPACITY-1];

    logic          busy_reg, busy_next;
    logic [CW-1:0] count_reg, count_next;

    logic          m_valid_reg, m_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [31:0]   out_data_reg, out_data_next;
    logic [CW-1:0] out_count_reg, out_count_next;

    logic          skid_valid_reg, skid_valid_next;
    status_t       skid_status_reg, skid_status_next;
    logic [31:0]   skid_data_reg, skid_data_next;
    logic [CW-1:0] skid_count_reg, skid_count_next;

    logic                 in_beat, tok_exit, out_free;
    status_t              res_status;
    logic signed [31:0]   res_data;
    logic [CW-1:0]        res_count;

    // Take a new beat only when the chain is empty and the skid stage can absorb a result.
    assign s_ready  = !busy_reg && !skid_valid_reg;
    assign in_beat  = s_valid && s_ready;
    assign tok_exit = tok_chain[CAPACITY].valid;
    assign out_free = !m_valid_reg || m_ready;

    // Launch the token into cell 0 at the accepting edge; the count is frozen with it.
    always_comb begin
        tok_chain[0].valid = in_beat;
        tok_chain[0].op    = op_t'(s_opcode);
        tok_chain[0].found = 1'b0;
        tok_chain[0].pos   = s_position;
        key_chain[0]       = DATA_WIDTH'(s_value);
        cnt_chain[0]       = count_reg;
        rdata_chain[0]     = '0;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] nbr;
        if (i < CAPACITY - 1) begin : g_mid
            assign nbr = entry_q[i+1];
        end else begin : g_end
            // last slot falls out of the list on a shift; its new value is never read
            assign nbr = entry_q[i];
        end

        olai_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .COUNT_W    (CW),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_in     (tok_chain[i]),
            .key_in     (key_chain[i]),
            .cnt_in     (cnt_chain[i]),
            .rdata_in   (rdata_chain[i]),
            .next_entry (nbr),
            .entry      (entry_q[i]),
            .tok_out    (tok_chain[i+1]),
            .key_out    (key_chain[i+1]),
            .cnt_out    (cnt_chain[i+1]),
            .rdata_out  (rdata_chain[i+1])
        );
    end

    // Form the result from the token leaving the last cell.
    always_comb begin
        res_status = ST_OK;
        res_data   = '0;
        res_count  = cnt_chain[CAPACITY];
        case (tok_chain[CAPACITY].op)
            OP_APPEND: begin
                if (cnt_chain[CAPACITY] == CAP_CNT) res_status = ST_FULL;
                else                                res_count  = cnt_chain[CAPACITY] + CW'(1);
            end
            OP_READ: begin
                if (tok_chain[CAPACITY].found) res_data   = 32'(signed'(rdata_chain[CAPACITY]));
                else                           res_status = ST_RANGE;
            end
            OP_REMOVE: begin
                if (tok_chain[CAPACITY].found) res_count  = cnt_chain[CAPACITY] - CW'(1);
                else                           res_status = ST_NOT_FOUND;
            end
            default: ;
        endcase
    end

    // Commit the count and free the chain as the token exits.
    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        if (in_beat)  busy_next = 1'b1;
        if (tok_exit) begin
            busy_next  = 1'b0;
            count_next = res_count;
        end
    end

    // Output register with a one-beat skid stage behind it.
    always_comb begin
        m_valid_next     = m_valid_reg;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_count_next   = out_count_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        skid_data_next   = skid_data_reg;
        skid_count_next  = skid_count_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                out_status_next = skid_status_reg;
                out_data_next   = skid_data_reg;
                out_count_next  = skid_count_reg;
                skid_valid_next = 1'b0;
            end else if (tok_exit) begin
                m_valid_next    = 1'b1;
                out_status_next = res_status;
                out_data_next   = res_data;
                out_count_next  = res_count;
            end else begin
                m_valid_next    = 1'b0;
            end
        end else if (tok_exit) begin
            // hold the new result until the waiting beat is taken
            skid_valid_next  = 1'b1;
            skid_status_next = res_status;
            skid_data_next   = res_data;
            skid_count_next  = res_count;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_count_reg   <= out_count_next;
        skid_status_reg <= skid_status_next;
        skid_data_reg   <= skid_data_next;
        skid_count_reg  <= skid_count_next;
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_status_reg;
    assign m_read_data   = out_data_reg;
    assign m_entry_count = COUNT_OUT_W'(out_count_reg);

`ifndef ASSERT_OFF
    a_exit_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |-> ##CAPACITY tok_exit)
        else $error("token did not leave the chain after CAPACITY cycles");

    a_exit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_exit |-> busy_reg)
        else $error("token left the chain while no operation was in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid stage holds a result while the output register is empty");
`endif

endmodule
